/* design/ile_pkg.sv */
// Package for the indexed list engine: sizes, op and status codes, cell command.
// No dependencies; every design file imports it.
package ile_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = 7;
   localparam int LEN_W  = 7;
   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   localparam int REQ_W  = 48;
   localparam int RSP_W  = 48;

   typedef enum logic [2:0] {
      OP_INSERT   = 3'd0,
      OP_APPEND   = 3'd1,
      OP_DELETE   = 3'd2,
      OP_DEL_LAST = 3'd3,
      OP_READ     = 3'd4,
      OP_WRITE    = 3'd5
   } op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic              shift_up;
      logic              shift_down;
      logic              write;
      logic [CMP_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

/* design/ile_cell.sv */
// One list slot: holds an entry and moves it to or from its neighbors.
// Depends on ile_pkg.
module ile_cell import ile_pkg::*; (
   input  logic              clock,
   input  cell_cmd_type      cmd,
   input  logic [CMP_W-1:0]  cell_idx,
   input  logic [DATA_W-1:0] left_entry,
   input  logic [DATA_W-1:0] right_entry,
   output logic [DATA_W-1:0] entry,
   output logic [DATA_W-1:0] pick
);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic              hit;
   logic              above;

   assign hit   = (cell_idx == cmd.pos);
   assign above = (cell_idx > cmd.pos);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift_up) begin
         if (above) begin
            entry_in = left_entry;
         end else if (hit) begin
            entry_in = cmd.value;
         end
      end else if (cmd.shift_down) begin
         if (above || hit) begin
            entry_in = right_entry;
         end
      end else if (cmd.write && hit) begin
         entry_in = cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign pick  = hit ? entry_ff : '0;

endmodule

/* design/indexed_list_engine.sv */
// A result is registered and appears in the cycle after its request transaction.
// One request per cycle unless stalled; an insert or delete is one shift of the cell row.
// A stalled result holds off requests; the next one enters in the cycle the result leaves.
// Reset (synchronous, active high) empties the list; slot contents are not cleared.
// Top level of the indexed list engine; depends on ile_pkg and ile_cell.
module indexed_list_engine import ile_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // op[2:0], index[9:3], value[41:10], zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // data[31:0], status[33:32], length[40:34], zero pad
);

   logic              req_accept;
   op_type            op;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] value;
   logic [CMP_W-1:0]  idx_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic              full;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]  rsp_length_ff, rsp_length_in;

   logic [1:0]        status;
   logic              do_ins, do_del, do_wr, do_pick;
   logic [CMP_W-1:0]  eff_pos;
   cell_cmd_type      cmd;

   logic [DATA_W-1:0] entry_w [DEPTH];
   logic [DATA_W-1:0] pick_w  [DEPTH];
   logic [DATA_W-1:0] pick_or;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign op      = op_type'(req_tdata[2:0]);
   assign index   = req_tdata[9:3];
   assign value   = req_tdata[41:10];
   assign idx_ext = CMP_W'(index);
   assign cnt_ext = CMP_W'(count_ff);
   assign full    = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      status  = ST_RANGE;
      do_ins  = 1'b0;
      do_del  = 1'b0;
      do_wr   = 1'b0;
      do_pick = 1'b0;
      eff_pos = idx_ext;
      case (op)
         OP_INSERT: begin
            if (idx_ext > cnt_ext) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               status = ST_OK;
               do_ins = 1'b1;
            end
         end
         OP_APPEND: begin
            eff_pos = cnt_ext;
            if (full) begin
               status = ST_FULL;
            end else begin
               status = ST_OK;
               do_ins = 1'b1;
            end
         end
         OP_DELETE: begin
            if (idx_ext < cnt_ext) begin
               status  = ST_OK;
               do_del  = 1'b1;
               do_pick = 1'b1;
            end
         end
         OP_DEL_LAST: begin
            eff_pos = cnt_ext - CMP_W'(1);
            if (count_ff != '0) begin
               status  = ST_OK;
               do_del  = 1'b1;
               do_pick = 1'b1;
            end
         end
         OP_READ: begin
            if (idx_ext < cnt_ext) begin
               status  = ST_OK;
               do_pick = 1'b1;
            end
         end
         OP_WRITE: begin
            if (idx_ext < cnt_ext) begin
               status = ST_OK;
               do_wr  = 1'b1;
            end
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
   end

   always_comb begin
      cmd.shift_up   = req_accept && do_ins;
      cmd.shift_down = req_accept && do_del;
      cmd.write      = req_accept && do_wr;
      cmd.pos        = eff_pos;
      cmd.value      = value;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_entry;
      logic [DATA_W-1:0] right_entry;
      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_mid_l
         assign left_entry = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid_r
         assign right_entry = entry_w[i+1];
      end
      ile_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_idx    (CMP_W'(i)),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .pick        (pick_w[i])
      );
   end

   always_comb begin
      pick_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pick_or = pick_or | pick_w[i];
      end
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      if (req_accept) begin
         if (do_ins) begin
            count_in = count_ff + CNT_W'(1);
         end else if (do_del) begin
            count_in = count_ff - CNT_W'(1);
         end
         rsp_valid_in  = 1'b1;
         rsp_data_in   = do_pick ? pick_or : '0;
         rsp_status_in = status;
         rsp_length_in = LEN_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_length_ff, rsp_status_ff, rsp_data_ff};

endmodule

/* design/ile_checker.sv */
// Port-level checks for indexed_list_engine, attached by bind.
// Depends on ile_pkg.
module ile_checker import ile_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic [1:0]       status;
   logic [LEN_W-1:0] length;

   assign status = rsp_tdata[33:32];
   assign length = rsp_tdata[40:34];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> status == ST_OK || status == ST_RANGE || status == ST_FULL)
      else $error("bad status code");

   a_err_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != ST_OK |-> rsp_tdata[31:0] == '0)
      else $error("data not zero on error");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == ST_FULL |-> length == LEN_W'(DEPTH))
      else $error("full status with list not full");

   a_len_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, length} <= (LEN_W + 1)'(DEPTH))
      else $error("length beyond depth");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (.*);

/* tb/sv/tb_top.sv */
// Testbench for indexed_list_engine: directed and random list requests over the stream ports,
// with a shadow list in a scoreboard class checking every response. Depends on ile_pkg.
`timescale 1ns / 100ps

module tb_top;
   import ile_pkg::*;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam int MODE_GROW   = 0;
   localparam int MODE_MIXED  = 1;
   localparam int MODE_SHRINK = 2;
   localparam int ITEMS_PER_PHASE = 620;

   typedef struct {
      logic [DATA_W-1:0] data;
      logic [1:0]        status;
      logic [LEN_W-1:0]  length;
   } list_response_type;

   class list_shadow_type;
      logic [DATA_W-1:0] slot [DEPTH];
      int                fill;
      list_response_type awaited [$];
      int                errors;

      function new();
         foreach (slot[i]) slot[i] = '0;
         fill   = 0;
         errors = 0;
      endfunction

      task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         errors++;
         $display("%0t ns: MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      endtask

      // Apply one accepted request to the shadow list and queue its response.
      function void note_request(logic [2:0] op, logic [IDX_W-1:0] idx,
                                 logic [DATA_W-1:0] val);
         list_response_type r;
         int                p;
         r.data   = '0;
         r.status = ST_RANGE;
         p = int'(idx);
         case (op)
            OP_INSERT, OP_APPEND: begin
               if (op == OP_APPEND) p = fill;
               if (p > fill) r.status = ST_RANGE;
               else if (fill >= DEPTH) r.status = ST_FULL;
               else begin
                  for (int i = fill; i > p; i--) slot[i] = slot[i-1];
                  slot[p] = val;
                  fill++;
                  r.status = ST_OK;
               end
            end
            OP_DELETE, OP_DEL_LAST: begin
               if (op == OP_DEL_LAST) p = fill - 1;
               if (p >= 0 && p < fill) begin
                  r.data = slot[p];
                  for (int i = p; i < fill - 1; i++) slot[i] = slot[i+1];
                  fill--;
                  r.status = ST_OK;
               end
            end
            OP_READ: begin
               if (p < fill) begin
                  r.data   = slot[p];
                  r.status = ST_OK;
               end
            end
            OP_WRITE: begin
               if (p < fill) begin
                  slot[p]  = val;
                  r.status = ST_OK;
               end
            end
            default: ;
         endcase
         r.length = fill[LEN_W-1:0];
         awaited.push_back(r);
      endfunction

      task check_result(logic [DATA_W-1:0] data, logic [1:0] status, logic [LEN_W-1:0] length);
         list_response_type w;
         if (awaited.size() == 0) begin
            report_mismatch("unexpected response", data, '0);
         end else begin
            w = awaited.pop_front();
            if (data !== w.data) report_mismatch("data", data, w.data);
            if (status !== w.status) report_mismatch("status", status, w.status);
            if (length !== w.length) report_mismatch("length", length, w.length);
         end
      endtask
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   int send_idle_pct  = 0;
   int rcv_stall_pct  = 0;
   int hold_off       = 0;

   list_shadow_type sb = new();

   indexed_list_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: long hold-off when requested, otherwise random stalls
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off = hold_off - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[31:0], rsp_tdata[33:32], rsp_tdata[40:34]);
   end

   task automatic send_item(logic [2:0] op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, val, idx, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, idx, val);
   endtask

   task automatic send_random(int mode);
      int                r;
      int                n;
      int                w [6];
      logic [2:0]        op;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] val;
      n = sb.fill;
      case (mode)
         MODE_GROW:   w = '{40, 30, 8, 6, 8, 6};
         MODE_SHRINK: w = '{8, 6, 36, 20, 14, 14};
         default:     w = '{17, 13, 17, 13, 20, 18};
      endcase
      r  = $urandom_range(99);
      op = ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
      if (r < w[0]) op = OP_INSERT;
      else if (r < w[0] + w[1]) op = OP_APPEND;
      else if (r < w[0] + w[1] + w[2]) op = OP_DELETE;
      else if (r < w[0] + w[1] + w[2] + w[3]) op = OP_DEL_LAST;
      else if (r < w[0] + w[1] + w[2] + w[3] + w[4]) op = OP_READ;
      else if (r < 98) op = OP_WRITE;
      if ($urandom_range(9) == 0 || op == OP_APPEND || op == OP_DEL_LAST)
         idx = IDX_W'($urandom);
      else if (op == OP_INSERT)
         idx = IDX_W'($urandom_range(n));
      else
         idx = IDX_W'((n > 0) ? $urandom_range(n - 1) : 0);
      case ($urandom_range(15))
         0:       val = 32'h8000_0000;
         1:       val = 32'h7fff_ffff;
         2:       val = 32'hffff_ffff;
         3:       val = 32'h0000_0000;
         default: val = $urandom;
      endcase
      send_item(op, idx, val);
   endtask

   initial begin
      int mode;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 6;
      rcv_stall_pct = 80;

      // empty list corner cases
      send_item(OP_READ, 7'd0, 32'h1234_5678);
      send_item(OP_DELETE, 7'd0, '0);
      send_item(OP_DEL_LAST, 7'd0, '0);
      send_item(OP_WRITE, 7'd0, 32'hdead_beef);
      send_item(OP_INSERT, 7'd1, 32'h1111_1111);
      send_item(OP_INSERT, 7'd127, 32'h2222_2222);
      // build a short list, read and edit it
      send_item(OP_INSERT, 7'd0, 32'h8000_0000);
      send_item(OP_APPEND, 7'd99, 32'h7fff_ffff);
      send_item(OP_INSERT, 7'd1, 32'hffff_ffff);
      send_item(OP_INSERT, 7'd0, 32'h0000_0001);
      send_item(OP_READ, 7'd0, '0);
      send_item(OP_READ, 7'd3, '0);
      send_item(OP_READ, 7'd4, '0);
      send_item(OP_READ, 7'd64, '0);
      send_item(OP_WRITE, 7'd2, 32'h0000_0000);
      send_item(OP_WRITE, 7'd4, 32'h5555_5555);
      send_item(OP_SPARE_A, 7'd0, 32'haaaa_aaaa);
      send_item(OP_SPARE_B, 7'd127, 32'hffff_ffff);
      send_item(OP_DELETE, 7'd1, '0);
      send_item(OP_DELETE, 7'd3, '0);
      send_item(OP_DEL_LAST, 7'd0, '0);
      send_item(OP_DEL_LAST, 7'd0, '0);
      send_item(OP_DELETE, 7'd0, '0);
      send_item(OP_DEL_LAST, 7'd0, '0);

      // grow to full, churn, drain to empty, repeatedly
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 6;  rcv_stall_pct = 80; end
            1: begin send_idle_pct = 80; rcv_stall_pct = 6;  end
            default: begin send_idle_pct = 0; rcv_stall_pct = 0; hold_off = 300; end
         endcase
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            case ((k / 70) % 5)
               0, 1:    mode = MODE_GROW;
               2:       mode = MODE_MIXED;
               default: mode = MODE_SHRINK;
            endcase
            send_random(mode);
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      for (int c = 0; c < 20000 && sb.awaited.size() != 0; c++) @(posedge clock);
      repeat (5) @(posedge clock);
      if (sb.awaited.size() != 0)
         sb.report_mismatch("responses missing", sb.awaited.size(), '0);
      if (sb.errors == 0) begin
         $display("indexed_list_engine test passed");
      end else begin
         $display("indexed_list_engine test failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("indexed_list_engine test failed");
      $finish;
   end

endmodule
